@@ rtl/core/mhpq_pkg.sv @@
// Package: types and constants of the min-heap priority queue.
`default_nettype none
package mhpq_pkg;
	localparam int Capacity = 1024;
	localparam int AddrBits = 10;
	localparam int CountBits = 11;
	localparam int KeyBits = 32;

	localparam logic [2:0] FUNC_INSERT = 3'd0;
	localparam logic [2:0] FUNC_DEL_MIN = 3'd1;
	localparam logic [2:0] FUNC_DECREASE = 3'd2;
	localparam logic [2:0] FUNC_INCREASE = 3'd3;
	localparam logic [2:0] FUNC_DEL_POS = 3'd4;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;
	localparam logic [1:0] STAT_RANGE = 2'd3;

	localparam logic signed [KeyBits-1:0] KEY_MAX = {1'b0, {(KeyBits-1){1'b1}}};
	localparam logic signed [KeyBits-1:0] KEY_MIN = {1'b1, {(KeyBits-1){1'b0}}};

	typedef struct packed {
		logic [2:0] func;
		logic signed [31:0] new_key;
		logic [9:0] position;
		logic [30:0] amount;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [31:0] removed_key;
		logic signed [31:0] min_key;
		logic [10:0] entry_total;
	} out_item_t;

	// memory port request from the sequencer
	typedef struct packed {
		logic we;
		logic [AddrBits-1:0] waddr;
		logic signed [KeyBits-1:0] wdata;
		logic [AddrBits-1:0] raddr;
	} mem_req_t;
endpackage
`default_nettype wire

@@ rtl/core/min_heap_priority_queue_unit.sv @@
// Top level: binary min-heap priority queue over one key memory.
// Each sift up level reads the parent and then compares; each sift down level reads the left
// child, then the right child, then compares and writes.
// Throughput: one transaction in flight; the next is accepted the cycle after the result
// transaction completes. Every compare waits on the key store's registered read port.
// Reset: arst_n clears the count and handshake state; the key store is not cleared.
`default_nettype none
module min_heap_priority_queue_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire mhpq_pkg::in_item_t in_data,
	output logic out_valid,
	input  wire logic out_ready,
	output mhpq_pkg::out_item_t out_data
);
	import mhpq_pkg::*;

	mem_req_t mreq;
	logic signed [KeyBits-1:0] rdata;

	// sequencer owns all control; memory holds the heap array
	mhpq_seq u_seq (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_data),
		.mreq(mreq), .rdata(rdata)
	);

	mhpq_ram u_ram (.clk(clk), .req(mreq), .rdata(rdata));

	// no new transaction while a result waits
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while result pending");
	// count never exceeds capacity
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.entry_total <= 11'(Capacity)) else $error("count overflow");
	// empty heap reports the largest key
	a_empty_min: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.entry_total == '0) |-> out_data.min_key == KEY_MAX)
		else $error("empty min");
endmodule
`default_nettype wire

@@ rtl/core/mhpq_ram.sv @@
// Heap key store: one write port, one registered read port.
`default_nettype none
module mhpq_ram (
	input  wire logic clk,
	input  wire mhpq_pkg::mem_req_t req,
	output logic signed [mhpq_pkg::KeyBits-1:0] rdata
);
	import mhpq_pkg::*;
	logic signed [KeyBits-1:0] mem [Capacity];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end
endmodule
`default_nettype wire

@@ rtl/core/mhpq_seq.sv @@
// Operation sequencer: checks, key update and sift walks over the key store.
`default_nettype none
module mhpq_seq (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire mhpq_pkg::in_item_t in_item,
	output logic out_valid,
	input  wire logic out_ready,
	output mhpq_pkg::out_item_t out_item,
	output mhpq_pkg::mem_req_t mreq,
	input  wire logic signed [mhpq_pkg::KeyBits-1:0] rdata
);
	import mhpq_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_RD_IDX = 4'd1;   // read slot under work
	localparam logic [3:0] ST_RD_END = 4'd2;   // slot key arrives, read last slot
	localparam logic [3:0] ST_LAST   = 4'd3;   // last slot key arrives
	localparam logic [3:0] ST_UP_RD  = 4'd4;   // read parent of the hole
	localparam logic [3:0] ST_UP_CMP = 4'd5;   // parent key arrives
	localparam logic [3:0] ST_DN_RL  = 4'd6;   // read left child
	localparam logic [3:0] ST_DN_RR  = 4'd7;   // left key arrives, read right child
	localparam logic [3:0] ST_DN_CMP = 4'd8;   // right key arrives
	localparam logic [3:0] ST_ROOTR  = 4'd9;   // read root
	localparam logic [3:0] ST_ROOT   = 4'd10;  // root key arrives, result out

	logic [3:0] state_q;
	logic [2:0] func_q;
	logic [30:0] amt_q;
	logic [CountBits-1:0] cnt_q;
	logic [AddrBits-1:0] idx_q;       // hole: slot the moving key belongs to
	logic signed [KeyBits-1:0] cur_q, lkey_q, removed_q;
	logic [1:0] status_q;
	logic down_after_q;  // delete at position: try down when up does not move
	logic moved_q;       // sift up moved the key
	logic [CountBits:0] lch, rch;
	logic [AddrBits-1:0] par;
	logic signed [KeyBits:0] adj;
	logic signed [KeyBits-1:0] sat_key;
	logic up_move, l_in, dn_lok, dn_rok, dn_move;

	assign lch = {1'b0, idx_q, 1'b1};
	assign rch = lch + (CountBits+1)'(1);
	assign par = (idx_q - AddrBits'(1)) >> 1;

	assign in_ready = (state_q == ST_IDLE) && !out_valid;

	always_comb begin
		adj = (func_q == FUNC_DECREASE) ? ($signed({rdata[KeyBits-1], rdata}) - $signed({2'b0, amt_q}))
			: ($signed({rdata[KeyBits-1], rdata}) + $signed({2'b0, amt_q}));
		sat_key = (adj > $signed({KEY_MAX[KeyBits-1], KEY_MAX})) ? KEY_MAX
			: (adj < $signed({KEY_MIN[KeyBits-1], KEY_MIN})) ? KEY_MIN
			: adj[KeyBits-1:0];
	end

	// compare terms; ties stay put, equal children pick the left one
	assign up_move = rdata > cur_q;
	assign l_in = lch < {1'b0, cnt_q};
	assign dn_lok = lkey_q < cur_q;
	assign dn_rok = (rch < {1'b0, cnt_q}) && (rdata < (dn_lok ? lkey_q : cur_q));
	assign dn_move = dn_lok || dn_rok;

	// key store request, one access of each kind per cycle
	always_comb begin
		mreq = '0;
		unique case (state_q)
			ST_RD_IDX: mreq.raddr = idx_q;
			ST_RD_END: mreq.raddr = AddrBits'(cnt_q - CountBits'(1));
			ST_UP_RD: begin
				if (idx_q == '0) begin
					if (!(down_after_q && !moved_q)) begin
						mreq.we = 1'b1;
						mreq.waddr = '0;
						mreq.wdata = cur_q;
					end
				end else begin
					mreq.raddr = par;
				end
			end
			ST_UP_CMP: begin
				if (up_move || !(down_after_q && !moved_q)) begin
					mreq.we = 1'b1;
					mreq.waddr = idx_q;
					mreq.wdata = up_move ? rdata : cur_q;
				end
			end
			ST_DN_RL: begin
				if (l_in) begin
					mreq.raddr = lch[AddrBits-1:0];
				end else begin
					mreq.we = 1'b1;
					mreq.waddr = idx_q;
					mreq.wdata = cur_q;
				end
			end
			ST_DN_RR: mreq.raddr = rch[AddrBits-1:0];
			ST_DN_CMP: begin
				mreq.we = 1'b1;
				mreq.waddr = idx_q;
				mreq.wdata = dn_move ? (dn_rok ? rdata : lkey_q) : cur_q;
			end
			ST_ROOTR: mreq.raddr = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid <= 1'b0;
			out_item <= '0;
			func_q <= '0;
			amt_q <= '0;
			idx_q <= '0;
			cur_q <= '0;
			lkey_q <= '0;
			removed_q <= '0;
			status_q <= STAT_OK;
			down_after_q <= 1'b0;
			moved_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						func_q <= in_item.func;
						amt_q <= in_item.amount;
						status_q <= STAT_OK;
						removed_q <= '0;
						down_after_q <= (in_item.func == FUNC_DEL_POS);
						moved_q <= 1'b0;
						state_q <= ST_ROOTR;
						unique case (in_item.func)
							FUNC_INSERT: begin
								if (cnt_q == CountBits'(Capacity)) begin
									status_q <= STAT_FULL;
								end else begin
									idx_q <= cnt_q[AddrBits-1:0];
									cur_q <= in_item.new_key;
									cnt_q <= cnt_q + CountBits'(1);
									state_q <= ST_UP_RD;
								end
							end
							FUNC_DEL_MIN: begin
								if (cnt_q == '0) begin
									status_q <= STAT_EMPTY;
									removed_q <= KEY_MAX;
								end else begin
									idx_q <= '0;
									state_q <= ST_RD_IDX;
								end
							end
							FUNC_DECREASE, FUNC_INCREASE, FUNC_DEL_POS: begin
								if (cnt_q == '0) begin
									status_q <= STAT_EMPTY;
								end else if ({1'b0, in_item.position} >= cnt_q) begin
									status_q <= STAT_RANGE;
								end else begin
									idx_q <= in_item.position;
									state_q <= ST_RD_IDX;
								end
							end
							default: ;
						endcase
					end
				end
				ST_RD_IDX: begin
					state_q <= ST_RD_END;
				end
				ST_RD_END: begin
					unique case (func_q)
						FUNC_DEL_MIN: begin
							removed_q <= rdata;
							cnt_q <= cnt_q - CountBits'(1);
							state_q <= ST_LAST;
						end
						FUNC_DEL_POS: begin
							cnt_q <= cnt_q - CountBits'(1);
							state_q <= ST_LAST;
						end
						FUNC_DECREASE: begin
							cur_q <= sat_key;
							state_q <= ST_UP_RD;
						end
						FUNC_INCREASE: begin
							cur_q <= sat_key;
							state_q <= ST_DN_RL;
						end
						default: state_q <= ST_ROOTR;
					endcase
				end
				ST_LAST: begin
					// last key fills the hole unless the hole was the last slot
					cur_q <= rdata;
					if ({1'b0, idx_q} >= cnt_q) begin
						state_q <= ST_ROOTR;
					end else begin
						state_q <= (func_q == FUNC_DEL_POS) ? ST_UP_RD : ST_DN_RL;
					end
				end
				ST_UP_RD: begin
					if (idx_q == '0) begin
						state_q <= (down_after_q && !moved_q) ? ST_DN_RL : ST_ROOTR;
					end else begin
						state_q <= ST_UP_CMP;
					end
				end
				ST_UP_CMP: begin
					if (up_move) begin
						idx_q <= par;
						moved_q <= 1'b1;
						state_q <= ST_UP_RD;
					end else begin
						state_q <= (down_after_q && !moved_q) ? ST_DN_RL : ST_ROOTR;
					end
				end
				ST_DN_RL: begin
					state_q <= l_in ? ST_DN_RR : ST_ROOTR;
				end
				ST_DN_RR: begin
					lkey_q <= rdata;
					state_q <= ST_DN_CMP;
				end
				ST_DN_CMP: begin
					if (dn_move) begin
						idx_q <= dn_rok ? rch[AddrBits-1:0] : lch[AddrBits-1:0];
						state_q <= ST_DN_RL;
					end else begin
						state_q <= ST_ROOTR;
					end
				end
				ST_ROOTR: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					out_valid <= 1'b1;
					out_item.status <= status_q;
					out_item.removed_key <= removed_q;
					out_item.min_key <= (cnt_q == '0) ? KEY_MAX : rdata;
					out_item.entry_total <= cnt_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
